### hw/rtl/spq_pkg.sv
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 16;

    localparam int PRIO_W     = 4;
    localparam int ID_FIELD_W = 16;
    localparam int OCC_W      = 5;
    localparam int STATUS_W   = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [PRIO_W-1:0] prio;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/spq_cell.sv
`default_nettype none
module spq_cell #(
    parameter int ID_WIDTH = spq_pkg::ID_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  spq_pkg::cell_ctrl_t        ctrl,
    input  logic [ID_WIDTH-1:0]        new_id,
    input  logic                       left_keep,
    input  logic                       left_valid,
    input  logic [ID_WIDTH-1:0]        left_id,
    input  logic [spq_pkg::PRIO_W-1:0] left_prio,
    input  logic                       right_valid,
    input  logic [ID_WIDTH-1:0]        right_id,
    input  logic [spq_pkg::PRIO_W-1:0] right_prio,
    output logic                       keep,
    output logic                       valid,
    output logic [ID_WIDTH-1:0]        id,
    output logic [spq_pkg::PRIO_W-1:0] prio
);

    logic                       valid_reg, valid_next;
    logic [ID_WIDTH-1:0]        id_reg, id_next;
    logic [spq_pkg::PRIO_W-1:0] prio_reg, prio_next;

    // entry stays put on insert when it is served no later than the new one
    assign keep  = valid_reg && (prio_reg <= ctrl.prio);
    assign valid = valid_reg;
    assign id    = id_reg;
    assign prio  = prio_reg;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (ctrl.ins) begin
            if (!keep) begin
                if (left_keep) begin
                    valid_next = 1'b1;
                    id_next    = new_id;
                    prio_next  = ctrl.prio;
                end else begin
                    valid_next = left_valid;
                    id_next    = left_id;
                    prio_next  = left_prio;
                end
            end
        end else if (ctrl.pop) begin
            valid_next = right_valid;
            id_next    = right_id;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule
`default_nettype wire

### hw/rtl/stable_priority_queue.sv
`default_nettype none
// Result: registered; it appears in the cycle after its input transfer.
// Throughput: one item per cycle; every cell of the row compares and shifts
// in the same cycle, and s_tready is low only while a result waits on m_tready.
// Reset: synchronous, active low; clears the cell valid bits, the entry count
// and the output valid. No clearing pass; the block is ready right after reset.
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = spq_pkg::ID_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // item_id[15:0], priority_req[19:16], zero fill
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_id[15:0], out_priority[19:16], occupancy[24:20], zero fill
    output logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [spq_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                       s_xfer;
    logic                       full, empty;
    logic [ID_WIDTH-1:0]        in_id;
    logic [spq_pkg::PRIO_W-1:0] in_prio;
    spq_pkg::cell_ctrl_t        ctrl;

    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    spq_pkg::status_t               status_reg, status_next;
    logic [spq_pkg::ID_FIELD_W-1:0] out_id_reg, out_id_next;
    logic [spq_pkg::PRIO_W-1:0]     out_prio_reg, out_prio_next;
    logic [spq_pkg::OCC_W-1:0]      occ_reg, occ_next;

    logic                       keep_w  [QUEUE_DEPTH];
    logic                       valid_w [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]        id_w    [QUEUE_DEPTH];
    logic [spq_pkg::PRIO_W-1:0] prio_w  [QUEUE_DEPTH];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign in_id    = ID_WIDTH'(s_tdata[15:0]);
    assign in_prio  = s_tdata[19:16];
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.ins  = s_xfer && (s_tuser[0] == spq_pkg::OP_INSERT) && !full;
    assign ctrl.pop  = s_xfer && (s_tuser[0] == spq_pkg::OP_REMOVE) && !empty;
    assign ctrl.prio = in_prio;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                       l_keep, l_valid, r_valid;
            logic [ID_WIDTH-1:0]        l_id, r_id;
            logic [spq_pkg::PRIO_W-1:0] l_prio, r_prio;

            if (gi == 0) begin : g_head
                assign l_keep  = 1'b1;
                assign l_valid = 1'b0;
                assign l_id    = '0;
                assign l_prio  = '0;
            end else begin : g_mid
                assign l_keep  = keep_w[gi-1];
                assign l_valid = valid_w[gi-1];
                assign l_id    = id_w[gi-1];
                assign l_prio  = prio_w[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign r_valid = 1'b0;
                assign r_id    = '0;
                assign r_prio  = '0;
            end else begin : g_body
                assign r_valid = valid_w[gi+1];
                assign r_id    = id_w[gi+1];
                assign r_prio  = prio_w[gi+1];
            end

            spq_cell #(
                .ID_WIDTH(ID_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_id     (in_id),
                .left_keep  (l_keep),
                .left_valid (l_valid),
                .left_id    (l_id),
                .left_prio  (l_prio),
                .right_valid(r_valid),
                .right_id   (r_id),
                .right_prio (r_prio),
                .keep       (keep_w[gi]),
                .valid      (valid_w[gi]),
                .id         (id_w[gi]),
                .prio       (prio_w[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        out_id_next   = out_id_reg;
        out_prio_next = out_prio_reg;
        occ_next      = occ_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (s_xfer) begin
            m_tvalid_next = 1'b1;
            out_id_next   = '0;
            out_prio_next = '0;
            occ_next      = spq_pkg::OCC_W'(count_next);
            if (s_tuser[0] == spq_pkg::OP_INSERT) begin
                status_next = full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
            end else if (empty) begin
                status_next = spq_pkg::STATUS_EMPTY;
            end else begin
                status_next   = spq_pkg::STATUS_OK;
                out_id_next   = spq_pkg::ID_FIELD_W'(id_w[0]);
                out_prio_next = prio_w[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        out_id_reg   <= out_id_next;
        out_prio_reg <= out_prio_next;
        occ_reg      <= occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, occ_reg, out_prio_reg, out_id_reg};

endmodule
`default_nettype wire

### hw/rtl/spq_checker.sv
`default_nettype none
module spq_assertions #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [spq_pkg::STATUS_W-1:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after input transfer");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == spq_pkg::STATUS_EMPTY) |-> (m_tdata == '0))
        else $error("remove on empty queue reports data");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == spq_pkg::STATUS_FULL) |->
            (m_tdata[19:0] == '0) &&
            (m_tdata[24:20] == spq_pkg::OCC_W'(QUEUE_DEPTH)))
        else $error("refused insert reports wrong data");

endmodule

bind stable_priority_queue spq_assertions #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (.*);
`default_nettype wire
